>>> rtl/core/xmodem_checksum_receiver_core_macros.svh
// ----------------------------------------------------------------------------
// XMODEM checksum receiver assertion macros
// Shared concurrent assertion forms for the receiver checker.
// ----------------------------------------------------------------------------
`ifndef XMODEM_CHECKSUM_RECEIVER_CORE_MACROS_SVH
`define XMODEM_CHECKSUM_RECEIVER_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define XMR_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("receiver check failed");

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define XMR_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("receiver check failed");

`endif

>>> rtl/core/xmr_pkg.sv
// ----------------------------------------------------------------------------
// xmr_pkg
// Types and constants shared by the XMODEM checksum receiver.
// ----------------------------------------------------------------------------
package xmr_pkg;

	// Frame geometry and store size.
	localparam logic [7:0]  PAYLOAD_BYTES = 8'd128;
	localparam logic [16:0] STORE_DEPTH   = 17'h10000;

	// Protocol bytes.
	localparam logic [7:0] BYTE_SOH = 8'h01;
	localparam logic [7:0] BYTE_ACK = 8'h06;
	localparam logic [7:0] BYTE_NAK = 8'h15;
	localparam logic [7:0] BYTE_EOT = 8'h04;
	localparam logic [7:0] BYTE_ALL = 8'hFF;

	// Item codes.
	localparam logic CMD_BYTE = 1'b0;
	localparam logic CMD_TICK = 1'b1;

	// Register indexes and reset values.
	localparam logic REG_BUFFER_LENGTH = 1'b0;
	localparam logic REG_TIMEOUT_TICKS = 1'b1;
	localparam logic [16:0] BUFFER_LENGTH_RESET = 17'h10000;
	localparam logic [15:0] TIMEOUT_TICKS_RESET = 16'd4000;

	typedef struct packed {
		logic       command;
		logic [7:0] rx_byte;
	} cmd_item_t;

	typedef struct packed {
		logic        send_valid;
		logic [7:0]  send_byte;
		logic        store_valid;
		logic [15:0] store_addr;
		logic [7:0]  store_data;
		logic        done_res;
		logic [16:0] done_length;
		logic        overflow_error;
	} res_item_t;

	// Configuration seen by the frame logic.
	typedef struct packed {
		logic [16:0] buffer_length;
		logic [15:0] timeout_ticks;
		logic        restart;
	} cfg_t;

endpackage

>>> rtl/core/xmodem_checksum_receiver_core.sv
// ----------------------------------------------------------------------------
// xmodem_checksum_receiver_core
// XMODEM receiver with 8-bit checksum: one reply/store/done result per item.
// ----------------------------------------------------------------------------
// Feed one transaction per received serial byte (command 0) or per time tick
// (command 1); each gives exactly one result transaction carrying an optional
// ACK/NAK reply, an optional store write of a payload byte, and an optional
// done report with the committed length or an overflow flag. The block takes
// one item per cycle while the result channel does not stall; each item passes
// an input register, a single-pass frame update, and a result register.
// The rate is set by the frame state update, a single combinational pass. Write
// buffer_length (address 0) or timeout_ticks (address 4) only while no work
// is in flight; a buffer_length write restarts the transfer at block 1.
// ----------------------------------------------------------------------------
module xmodem_checksum_receiver_core import xmr_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	// Item channel
	input  logic        cmd_valid,
	output logic        cmd_stall,
	input  cmd_item_t   cmd_item,
	// Result channel
	output logic        res_valid,
	input  logic        res_stall,
	output res_item_t   res_item,
	// Configuration port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	cfg_t      cfg;
	logic      valid_s1;
	cmd_item_t item_s1;
	logic      room;
	logic      advance;
	res_item_t res_d;

	xmr_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Advance the input stage whenever the result register has room;
	// stall the source only while a held item cannot move on.
	assign advance   = valid_s1 && room;
	assign cmd_stall = valid_s1 && !room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!cmd_stall) begin
			valid_s1 <= cmd_valid;
		end
	end

	// Capture the payload on every accepted transaction; hold it while stalled.
	always_ff @(posedge clk) begin
		if (cmd_valid && !cmd_stall) begin
			item_s1 <= cmd_item;
		end
	end

	// Update the frame state and form the result in one pass.
	xmr_frame_fsm u_fsm (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.fire   (advance),
		.item   (item_s1),
		.res    (res_d)
	);

	// Hold the result until the sink takes it.
	xmr_result_reg u_res (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (valid_s1),
		.res_in    (res_d),
		.res_stall (res_stall),
		.res_valid (res_valid),
		.res_item  (res_item),
		.room      (room)
	);

endmodule

>>> rtl/core/xmr_cfg_regs.sv
// ----------------------------------------------------------------------------
// xmr_cfg_regs
// APB-style register file: buffer length and timeout ticks.
// ----------------------------------------------------------------------------
module xmr_cfg_regs import xmr_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	output cfg_t        cfg
);

	logic [16:0] buffer_length_q;
	logic [15:0] timeout_ticks_q;
	logic        wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			buffer_length_q <= BUFFER_LENGTH_RESET;
			timeout_ticks_q <= TIMEOUT_TICKS_RESET;
		end else begin
			if (wr_en) begin
				case (paddr[2])
					REG_BUFFER_LENGTH: begin
						buffer_length_q <= pwdata[16:0];
					end
					REG_TIMEOUT_TICKS: begin
						timeout_ticks_q <= pwdata[15:0];
					end
					default: begin
					end
				endcase
			end
		end
	end

	always_comb begin
		case (paddr[2])
			REG_BUFFER_LENGTH: prdata = {15'd0, buffer_length_q};
			REG_TIMEOUT_TICKS: prdata = {16'd0, timeout_ticks_q};
			default:           prdata = '0;
		endcase
	end

	// Restart the transfer at the same edge that writes a new buffer length.
	assign cfg.buffer_length = buffer_length_q;
	assign cfg.timeout_ticks = timeout_ticks_q;
	assign cfg.restart       = wr_en && (paddr[2] == REG_BUFFER_LENGTH);

endmodule

>>> rtl/core/xmr_frame_fsm.sv
// ----------------------------------------------------------------------------
// xmr_frame_fsm
// Frame state and single-pass result for one received byte or tick.
// ----------------------------------------------------------------------------
module xmr_frame_fsm import xmr_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  cfg_t      cfg,
	input  logic      fire,
	input  cmd_item_t item,
	output res_item_t res
);

	typedef enum logic [2:0] {
		PH_START,
		PH_NUMBER,
		PH_INVERSE,
		PH_DATA,
		PH_SUM
	} phase_t;

	phase_t      phase_q, phase_d;
	logic [7:0]  block_q, block_d;
	logic [7:0]  index_q, index_d;
	logic [7:0]  sum_q, sum_d;
	logic [16:0] offset_q, offset_d;
	logic [15:0] idle_q, idle_d;

	logic [16:0] idle_next;
	logic [16:0] limit;
	logic [17:0] pos;
	logic [7:0]  index_inc;

	assign idle_next = {1'b0, idle_q} + 17'd1;
	assign limit     = (cfg.buffer_length > STORE_DEPTH) ? STORE_DEPTH : cfg.buffer_length;
	assign pos       = {1'b0, offset_q} + {10'd0, index_q};
	assign index_inc = index_q + 8'd1;

	always_comb begin
		phase_d  = phase_q;
		block_d  = block_q;
		index_d  = index_q;
		sum_d    = sum_q;
		offset_d = offset_q;
		idle_d   = idle_q;
		res      = '0;
		if (item.command == CMD_TICK) begin
			if (idle_next >= {1'b0, cfg.timeout_ticks}) begin
				idle_d         = '0;
				res.send_valid = 1'b1;
				res.send_byte  = BYTE_NAK;
				phase_d        = PH_START;
				index_d        = '0;
				sum_d          = '0;
			end else begin
				idle_d = idle_next[15:0];
			end
		end else begin
			idle_d = '0;
			case (phase_q)
				PH_START: begin
					if (item.rx_byte == BYTE_EOT) begin
						res.send_valid  = 1'b1;
						res.send_byte   = BYTE_ACK;
						res.done_res    = 1'b1;
						res.done_length = offset_q;
						block_d         = 8'd1;
						offset_d        = '0;
						index_d         = '0;
						sum_d           = '0;
					end else if (item.rx_byte == BYTE_SOH) begin
						phase_d = PH_NUMBER;
					end else begin
						res.send_valid = 1'b1;
						res.send_byte  = BYTE_NAK;
						index_d        = '0;
						sum_d          = '0;
					end
				end
				PH_NUMBER: begin
					if (item.rx_byte == block_q) begin
						phase_d = PH_INVERSE;
					end else begin
						res.send_valid = 1'b1;
						res.send_byte  = BYTE_NAK;
						phase_d        = PH_START;
						index_d        = '0;
						sum_d          = '0;
					end
				end
				PH_INVERSE: begin
					if (item.rx_byte == (BYTE_ALL - block_q)) begin
						phase_d = PH_DATA;
					end else begin
						res.send_valid = 1'b1;
						res.send_byte  = BYTE_NAK;
						phase_d        = PH_START;
					end
					index_d = '0;
					sum_d   = '0;
				end
				PH_DATA: begin
					if (pos >= {1'b0, limit}) begin
						res.send_valid     = 1'b1;
						res.send_byte      = BYTE_NAK;
						res.done_res       = 1'b1;
						res.overflow_error = 1'b1;
						phase_d            = PH_START;
						block_d            = 8'd1;
						offset_d           = '0;
						index_d            = '0;
						sum_d              = '0;
					end else begin
						res.store_valid = 1'b1;
						res.store_addr  = pos[15:0];
						res.store_data  = item.rx_byte;
						sum_d           = sum_q + item.rx_byte;
						index_d         = index_inc;
						if (index_inc >= PAYLOAD_BYTES) begin
							phase_d = PH_SUM;
						end
					end
				end
				PH_SUM: begin
					res.send_valid = 1'b1;
					if (item.rx_byte != sum_q) begin
						res.send_byte = BYTE_NAK;
					end else begin
						res.send_byte = BYTE_ACK;
						block_d       = block_q + 8'd1;
						offset_d      = offset_q + {9'd0, PAYLOAD_BYTES};
					end
					phase_d = PH_START;
					index_d = '0;
					sum_d   = '0;
				end
				default: begin
					phase_d = PH_START;
					index_d = '0;
					sum_d   = '0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_START;
			block_q  <= 8'd1;
			index_q  <= '0;
			sum_q    <= '0;
			offset_q <= '0;
			idle_q   <= '0;
		end else if (cfg.restart) begin
			// New buffer: restart the transfer, keep the idle count.
			phase_q  <= PH_START;
			block_q  <= 8'd1;
			index_q  <= '0;
			sum_q    <= '0;
			offset_q <= '0;
		end else if (fire) begin
			phase_q  <= phase_d;
			block_q  <= block_d;
			index_q  <= index_d;
			sum_q    <= sum_d;
			offset_q <= offset_d;
			idle_q   <= idle_d;
		end
	end

endmodule

>>> rtl/core/xmr_result_reg.sv
// ----------------------------------------------------------------------------
// xmr_result_reg
// Result register that holds a transaction until the sink takes it.
// ----------------------------------------------------------------------------
module xmr_result_reg import xmr_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      load,
	input  res_item_t res_in,
	input  logic      res_stall,
	output logic      res_valid,
	output res_item_t res_item,
	output logic      room
);

	logic      valid_q;
	res_item_t item_q;

	// Free when empty or when the held transaction leaves this cycle.
	assign room = !valid_q || !res_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (room) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (room && load) begin
			item_q <= res_in;
		end
	end

	assign res_valid = valid_q;
	assign res_item  = item_q;

endmodule

>>> rtl/core/xmr_checker.sv
// ----------------------------------------------------------------------------
// xmr_checker
// Port-level assertions for the XMODEM checksum receiver, bound to the core.
// ----------------------------------------------------------------------------
`include "xmodem_checksum_receiver_core_macros.svh"

module xmr_checker import xmr_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      res_valid,
	input logic      res_stall,
	input res_item_t res_item
);

	// A stalled result transaction stays and holds its payload.
	`XMR_ASSERT_NEXT(a_res_hold, res_valid && res_stall, res_valid && $stable(res_item))

	// No reply byte without a reply.
	`XMR_ASSERT_NOW(a_send_clean, res_valid && !res_item.send_valid, res_item.send_byte == 8'd0)

	// A store write never shares a transaction with a reply or a done report.
	`XMR_ASSERT_NOW(a_store_alone, res_valid && res_item.store_valid,
		!res_item.send_valid && !res_item.done_res)

	// Overflow ends the transfer with a NAK and zero length.
	`XMR_ASSERT_NOW(a_overflow, res_valid && res_item.overflow_error,
		res_item.done_res && res_item.send_valid && (res_item.send_byte == BYTE_NAK)
		&& (res_item.done_length == 17'd0))

endmodule

bind xmodem_checksum_receiver_core xmr_checker u_xmr_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.res_valid (res_valid),
	.res_stall (res_stall),
	.res_item  (res_item)
);

>>> sim/xmodem_checksum_receiver_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xmodem_checksum_receiver_core_tb
// Self-checking bench for the XMODEM checksum receiver core.
// ----------------------------------------------------------------------------
// Drives received bytes and time ticks through the item channel in bursts. A
// built-in model of the receiver predicts one result per accepted
// transaction. Every accepted result is compared field by field in arrival
// order. The configuration registers are written and read back over APB
// between phases. Coverage: directed protocol corner cases, a small store
// filled to its last byte and then overrun, and randomized sessions of good,
// damaged and truncated frames under several buffer and timeout settings.
// ----------------------------------------------------------------------------
module xmodem_checksum_receiver_core_tb import xmr_pkg::*; ();

	// Bench sizing
	localparam int RANDOM_ITEMS   = 1200;
	localparam int RANDOM_PHASES  = 6;
	localparam int FULL_BLOCKS    = 2;
	localparam int DRAIN_CYCLES   = 8;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int MAX_REPORTS    = 50;

	// Register byte addresses, derived from the register indexes
	localparam logic [2:0] ADDR_BUFFER_LENGTH = {REG_BUFFER_LENGTH, 2'b00};
	localparam logic [2:0] ADDR_TIMEOUT_TICKS = {REG_TIMEOUT_TICKS, 2'b00};

	// Receiver frame phases, as tracked by the predictor
	typedef enum logic [2:0] {
		RX_START,
		RX_NUMBER,
		RX_INVERSE,
		RX_DATA,
		RX_SUM
	} rx_phase_t;

	// Ways a generated frame can be damaged
	typedef enum int {
		FLAW_NONE,
		FLAW_START,
		FLAW_NUMBER,
		FLAW_INVERSE,
		FLAW_SUM,
		FLAW_SHORT
	} frame_flaw_t;

	// Receiver backpressure patterns
	typedef enum int {
		STALL_NONE,
		STALL_LIGHT,
		STALL_HEAVY,
		STALL_WAVE
	} stall_mode_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cmd_valid;
	logic        cmd_stall;
	cmd_item_t   cmd_item;
	logic        res_valid;
	logic        res_stall = 1'b0;
	res_item_t   res_item;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	// Predictor state and its copy of the registers
	rx_phase_t   rx_phase;
	logic [7:0]  exp_block;
	logic [7:0]  pay_index;
	logic [7:0]  run_sum;
	logic [16:0] commit_off;
	logic [15:0] idle_cnt;
	logic [16:0] cfg_buf_len;
	logic [15:0] cfg_timeout;

	// Results predicted but not yet seen, oldest first
	res_item_t   pending_results[$];

	// Tallies
	int error_count  = 0;
	int item_count   = 0;
	int result_count = 0;
	int ack_count    = 0;
	int nak_count    = 0;
	int store_count  = 0;
	int done_count   = 0;
	int ovf_count    = 0;
	int config_count = 0;
	int burst_left   = 0;
	int idle_cycles  = 0;

	stall_mode_t stall_mode = STALL_NONE;
	int          stall_left = 0;

	xmodem_checksum_receiver_core DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd_item  (cmd_item),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res_item  (res_item),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready)
	);

	// 2 ns clock
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------

	// Drop a partly received block and wait for SOH again.
	function automatic void drop_block();
		rx_phase  = RX_START;
		pay_index = '0;
		run_sum   = '0;
	endfunction

	// Start the whole transfer over at block 1, offset 0.
	function automatic void drop_transfer();
		drop_block();
		exp_block  = 8'd1;
		commit_off = '0;
	endfunction

	function automatic void predictor_reset();
		cfg_buf_len = BUFFER_LENGTH_RESET;
		cfg_timeout = TIMEOUT_TICKS_RESET;
		drop_transfer();
		idle_cnt = '0;
	endfunction

	// Advance the receiver by one transaction and return the result it gives.
	function automatic res_item_t predict_xmodem(input cmd_item_t it);
		res_item_t   r;
		logic [7:0]  reply;
		logic [16:0] next_idle;
		logic [17:0] pos;
		logic [17:0] limit;
		r     = '0;
		reply = '0;
		if (it.command == CMD_TICK) begin
			// Count idle ticks; a timeout asks for the block again.
			next_idle = {1'b0, idle_cnt} + 17'd1;
			if (next_idle >= {1'b0, cfg_timeout}) begin
				idle_cnt = '0;
				reply    = BYTE_NAK;
				drop_block();
			end else begin
				idle_cnt = next_idle[15:0];
			end
		end else begin
			idle_cnt = '0;
			case (rx_phase)
				RX_START: begin
					if (it.rx_byte == BYTE_EOT) begin
						reply         = BYTE_ACK;
						r.done_res    = 1'b1;
						r.done_length = commit_off;
						drop_transfer();
					end else if (it.rx_byte == BYTE_SOH) begin
						rx_phase = RX_NUMBER;
					end else begin
						reply = BYTE_NAK;
						drop_block();
					end
				end
				RX_NUMBER: begin
					if (it.rx_byte == exp_block) begin
						rx_phase = RX_INVERSE;
					end else begin
						reply = BYTE_NAK;
						drop_block();
					end
				end
				RX_INVERSE: begin
					if (it.rx_byte == BYTE_ALL - exp_block) begin
						rx_phase  = RX_DATA;
						pay_index = '0;
						run_sum   = '0;
					end else begin
						reply = BYTE_NAK;
						drop_block();
					end
				end
				RX_DATA: begin
					// The usable length never exceeds the store.
					limit = {1'b0, (cfg_buf_len > STORE_DEPTH) ? STORE_DEPTH : cfg_buf_len};
					pos   = {1'b0, commit_off} + {10'd0, pay_index};
					if (pos >= limit) begin
						reply            = BYTE_NAK;
						r.done_res       = 1'b1;
						r.done_length    = '0;
						r.overflow_error = 1'b1;
						drop_transfer();
					end else begin
						r.store_valid = 1'b1;
						r.store_addr  = pos[15:0];
						r.store_data  = it.rx_byte;
						run_sum       = run_sum + it.rx_byte;
						pay_index     = pay_index + 8'd1;
						if (pay_index >= PAYLOAD_BYTES)
							rx_phase = RX_SUM;
					end
				end
				RX_SUM: begin
					if (it.rx_byte != run_sum) begin
						reply = BYTE_NAK;
					end else begin
						reply      = BYTE_ACK;
						exp_block  = exp_block + 8'd1;
						commit_off = commit_off + {9'd0, PAYLOAD_BYTES};
					end
					drop_block();
				end
				default: drop_block();
			endcase
		end
		if (reply != '0) begin
			r.send_valid = 1'b1;
			r.send_byte  = reply;
		end
		return r;
	endfunction

	// ------------------------------------------------------------------
	// Mismatch reporting
	// ------------------------------------------------------------------

	task automatic report_mismatch(input string what);
		error_count++;
		if (error_count <= MAX_REPORTS)
			$display("MISMATCH @%0t ns: %s", $time, what);
	endtask

	task automatic check_field(input string name, input int unsigned got,
			input int unsigned want);
		if (got != want)
			report_mismatch($sformatf("%s: got 0x%0h, want 0x%0h", name, got, want));
	endtask

	// ------------------------------------------------------------------
	// Result checker: compare each accepted result with the oldest prediction
	// ------------------------------------------------------------------
	always @(posedge clk) begin : result_check
		res_item_t want;
		if (arst_n && res_valid && !res_stall) begin
			result_count++;
			if (pending_results.size() == 0) begin
				report_mismatch("result transaction with nothing pending");
			end else begin
				want = pending_results.pop_front();
				check_field("send_valid", 32'(res_item.send_valid), 32'(want.send_valid));
				check_field("send_byte", 32'(res_item.send_byte), 32'(want.send_byte));
				check_field("store_valid", 32'(res_item.store_valid),
					32'(want.store_valid));
				check_field("store_addr", 32'(res_item.store_addr), 32'(want.store_addr));
				check_field("store_data", 32'(res_item.store_data), 32'(want.store_data));
				check_field("done_res", 32'(res_item.done_res), 32'(want.done_res));
				check_field("done_length", 32'(res_item.done_length),
					32'(want.done_length));
				check_field("overflow_error", 32'(res_item.overflow_error),
					32'(want.overflow_error));
				if (want.send_valid && want.send_byte == BYTE_ACK)
					ack_count++;
				if (want.send_valid && want.send_byte == BYTE_NAK)
					nak_count++;
				if (want.store_valid)
					store_count++;
				if (want.done_res)
					done_count++;
				if (want.overflow_error)
					ovf_count++;
			end
		end
	end

	// ------------------------------------------------------------------
	// Result backpressure: switch at random between patterns of stall cycles
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (stall_left == 0) begin
			stall_mode <= stall_mode_t'($urandom_range(STALL_NONE, STALL_WAVE));
			stall_left <= $urandom_range(32, 256);
		end else begin
			stall_left <= stall_left - 1;
		end
		case (stall_mode)
			STALL_NONE:  res_stall <= 1'b0;
			STALL_LIGHT: res_stall <= ($urandom_range(0, 3) == 0);
			STALL_HEAVY: res_stall <= ($urandom_range(0, 1) == 0);
			default:     res_stall <= ((stall_left % 8) < 3);
		endcase
	end

	// ------------------------------------------------------------------
	// Watchdog: end the run when no transaction moves for too long
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if ((cmd_valid && !cmd_stall) || (res_valid && !res_stall)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("Watchdog: no transaction for %0d cycles, %0d results pending",
				idle_cycles, pending_results.size());
			$display("CHECKS FAILED");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// ------------------------------------------------------------------
	// Item channel driver
	// ------------------------------------------------------------------

	// Present one transaction and hold it until accepted. Bursts of random
	// length are separated by random gaps; half the gaps are empty so that
	// long unbroken stretches occur too.
	task automatic send_item(input cmd_item_t it);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 4);
			if (gap > 0) begin
				cmd_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
		burst_left--;
		cmd_item  <= it;
		cmd_valid <= 1'b1;
		@(posedge clk);
		while (cmd_stall)
			@(posedge clk);
		// Accepted at this edge: predict its result now.
		pending_results.push_back(predict_xmodem(it));
		item_count++;
	endtask

	task automatic send_rx(input logic [7:0] b);
		cmd_item_t it;
		it.command = CMD_BYTE;
		it.rx_byte = b;
		send_item(it);
	endtask

	// A tick carries a random, unused byte field.
	task automatic send_tick();
		cmd_item_t it;
		it.command = CMD_TICK;
		it.rx_byte = 8'($urandom_range(0, 255));
		send_item(it);
	endtask

	function automatic logic [7:0] nonzero8();
		nonzero8 = 8'($urandom_range(1, 255));
	endfunction

	// Send one frame for the block the receiver waits for. A header flaw
	// stops the frame at the bad byte; a short frame stops inside the data.
	task automatic send_block(input frame_flaw_t flaw, input bit ticks_inside);
		logic [7:0] blk;
		logic [7:0] sum;
		logic [7:0] b;
		int         cut;
		blk = exp_block;
		sum = '0;
		if (flaw == FLAW_START) begin
			do
				b = 8'($urandom_range(0, 255));
			while (b == BYTE_SOH || b == BYTE_EOT);
			send_rx(b);
			return;
		end
		send_rx(BYTE_SOH);
		if (flaw == FLAW_NUMBER) begin
			send_rx(blk ^ nonzero8());
			return;
		end
		send_rx(blk);
		if (flaw == FLAW_INVERSE) begin
			send_rx((BYTE_ALL - blk) ^ nonzero8());
			return;
		end
		send_rx(BYTE_ALL - blk);
		cut = (flaw == FLAW_SHORT) ? $urandom_range(0, PAYLOAD_BYTES - 1) : PAYLOAD_BYTES;
		for (int i = 0; i < cut; i++) begin
			if (ticks_inside && $urandom_range(0, 31) == 0)
				send_tick();
			b = 8'($urandom_range(0, 255));
			sum = sum + b;
			send_rx(b);
		end
		if (flaw == FLAW_SHORT)
			return;
		send_rx((flaw == FLAW_SUM) ? (sum ^ nonzero8()) : sum);
	endtask

	// Drop valid, wait for every pending result, then let the pipe drain.
	task automatic settle();
		cmd_valid <= 1'b0;
		burst_left = 0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// ------------------------------------------------------------------
	// Configuration port
	// ------------------------------------------------------------------

	// Setup phase, access phase, then a return to idle so that back-to-back
	// calls never assign psel twice in one step.
	task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
	endtask

	task automatic apb_read(input logic [2:0] addr, output logic [31:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= addr;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		data = prdata;
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	// Write both registers while idle, mirror them in the predictor and
	// read them back.
	task automatic set_config(input logic [16:0] buf_len, input logic [15:0] ticks);
		logic [31:0] readback;
		settle();
		apb_write(ADDR_BUFFER_LENGTH, {15'd0, buf_len});
		cfg_buf_len = buf_len;
		drop_transfer();
		apb_write(ADDR_TIMEOUT_TICKS, {16'd0, ticks});
		cfg_timeout = ticks;
		apb_read(ADDR_BUFFER_LENGTH, readback);
		check_field("buffer_length readback", readback, {15'd0, buf_len});
		apb_read(ADDR_TIMEOUT_TICKS, readback);
		check_field("timeout_ticks readback", readback, {16'd0, ticks});
		config_count++;
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	task automatic test_reset_values();
		logic [31:0] readback;
		apb_read(ADDR_BUFFER_LENGTH, readback);
		check_field("buffer_length after reset", readback, {15'd0, BUFFER_LENGTH_RESET});
		apb_read(ADDR_TIMEOUT_TICKS, readback);
		check_field("timeout_ticks after reset", readback, {16'd0, TIMEOUT_TICKS_RESET});
	endtask

	task automatic test_directed();
		// Reset settings: EOT with nothing committed, stray start bytes at
		// both ends of the byte range, a wrong block number, a wrong
		// complement, and a tick far below the timeout.
		send_rx(BYTE_EOT);
		send_rx(8'h00);
		send_rx(8'hFF);
		send_rx(BYTE_SOH);
		send_rx(8'h02);
		send_rx(BYTE_SOH);
		send_rx(8'h01);
		send_rx(8'h00);
		send_tick();

		// Empty buffer, shortest timeout: every tick times out and the first
		// data byte overflows.
		set_config(17'd0, 16'd1);
		send_tick();
		send_rx(BYTE_SOH);
		send_rx(8'h01);
		send_rx(BYTE_ALL - 8'h01);
		send_rx(8'h00);
		send_rx(BYTE_EOT);

		// One-byte buffer, longest timeout: one byte lands, the next overflows.
		set_config(17'd1, 16'hFFFF);
		send_rx(BYTE_SOH);
		send_rx(8'h01);
		send_rx(BYTE_ALL - 8'h01);
		send_rx(8'hFF);
		send_rx(8'h80);
		send_tick();
		send_tick();
	endtask

	// Fill a small store to its last byte, then push one data byte past it;
	// the abort leaves nothing committed for the EOT that follows.
	task automatic test_full_store();
		logic [7:0] blk;
		set_config(17'(FULL_BLOCKS * PAYLOAD_BYTES), 16'hFFFF);
		for (int n = 0; n < FULL_BLOCKS; n++)
			send_block(FLAW_NONE, $urandom_range(0, 7) == 0);
		blk = exp_block;
		send_rx(BYTE_SOH);
		send_rx(blk);
		send_rx(BYTE_ALL - blk);
		send_rx(8'h5A);
		send_rx(BYTE_EOT);
	endtask

	// Random sessions: mostly well-formed frames with random content, mixed
	// with damaged frames, truncated frames, EOTs, line noise and tick runs.
	task automatic test_random_traffic();
		int          phase_start;
		int          roll;
		logic [16:0] buf_len;
		logic [15:0] ticks;
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			case ($urandom_range(0, 5))
				0:       buf_len = 17'd0;
				1:       buf_len = 17'($urandom_range(1, PAYLOAD_BYTES - 1));
				2:       buf_len = {9'd0, PAYLOAD_BYTES};
				3:       buf_len = 17'($urandom_range(PAYLOAD_BYTES + 1, 600));
				4:       buf_len = STORE_DEPTH;
				default: buf_len = 17'($urandom_range(0, STORE_DEPTH));
			endcase
			case ($urandom_range(0, 3))
				0:       ticks = 16'd1;
				1:       ticks = 16'($urandom_range(2, 40));
				2:       ticks = 16'hFFFF;
				default: ticks = 16'($urandom_range(1, 16'hFFFF));
			endcase
			set_config(buf_len, ticks);
			phase_start = item_count;
			while (item_count - phase_start < RANDOM_ITEMS / RANDOM_PHASES) begin
				roll = $urandom_range(0, 99);
				if (roll < 55) begin
					send_block(FLAW_NONE, roll < 10);
				end else if (roll < 63) begin
					send_block(FLAW_SUM, 1'b0);
				end else if (roll < 68) begin
					send_block(FLAW_NUMBER, 1'b0);
				end else if (roll < 73) begin
					send_block(FLAW_INVERSE, 1'b0);
				end else if (roll < 78) begin
					send_block(FLAW_START, 1'b0);
				end else if (roll < 83) begin
					// Truncated frame; let a short timeout recover it.
					send_block(FLAW_SHORT, 1'b0);
					if (cfg_timeout <= 16'd40)
						repeat (cfg_timeout) send_tick();
				end else if (roll < 90) begin
					send_rx(BYTE_EOT);
				end else if (roll < 95) begin
					repeat ($urandom_range(1, 4)) send_rx(8'($urandom_range(0, 255)));
				end else begin
					repeat ($urandom_range(1, 8)) send_tick();
				end
			end
		end
	endtask

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------
	initial begin
		arst_n    <= 1'b0;
		cmd_valid <= 1'b0;
		cmd_item  <= '0;
		psel      <= 1'b0;
		penable   <= 1'b0;
		pwrite    <= 1'b0;
		paddr     <= '0;
		pwdata    <= '0;
		predictor_reset();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_values();
		test_directed();
		test_full_store();
		test_random_traffic();
		settle();

		$display("Ran %0d items into %0d results: %0d ACK, %0d NAK, %0d stored bytes",
			item_count, result_count, ack_count, nak_count, store_count);
		$display("Saw %0d transfer ends, %0d overflow aborts, over %0d register settings",
			done_count, ovf_count, config_count);
		if (error_count == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("%0d mismatches", error_count);
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
